### hdl/pdts_pkg.sv
`default_nettype none
package pdts_pkg;

  // Command codes
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_STOP  = 2'd2;

  // Verdict codes
  localparam logic [1:0] VERDICT_RUNNING = 2'd0;
  localparam logic [1:0] VERDICT_FAILED  = 2'd1;
  localparam logic [1:0] VERDICT_PASSED  = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_LIMIT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_PRES_MAX = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PUMP_TIMEOUT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FWD_STOP_VOL   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RTN_STOP_VOL   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STILL_LIMIT    = 3'd6;

  // Pump bit positions in the run vector
  localparam int unsigned PUMP_INLET  = 0;
  localparam int unsigned PUMP_AC     = 1;
  localparam int unsigned PUMP_RETURN = 2;

  typedef struct packed {
    logic signed [13:0] decay_limit;
    logic signed [14:0] start_pressure_max;
    logic [15:0]        hold_time_ms;
    logic [15:0]        pump_timeout_ms;
    logic [15:0]        forward_stop_volume;
    logic [15:0]        return_stop_volume;
    logic [7:0]         still_limit;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [14:0] pressure;
    logic signed [15:0] inlet_delta;
    logic signed [15:0] ac_delta;
    logic signed [15:0] return_delta;
    logic [9:0]         elapsed_ms;
  } item_t;

endpackage
`default_nettype wire

### hdl/pdts_if.sv
`default_nettype none
interface pdts_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic signed [14:0] pressure;
  logic signed [15:0] inlet_delta;
  logic signed [15:0] ac_delta;
  logic signed [15:0] return_delta;
  logic [9:0]         elapsed_ms;

  modport source (output valid, cmd, pressure, inlet_delta, ac_delta, return_delta,
                  elapsed_ms, input ready);
  modport sink (input valid, cmd, pressure, inlet_delta, ac_delta, return_delta,
                elapsed_ms, output ready);
endinterface

interface pdts_out_if;
  logic       valid;
  logic       ready;
  logic       inlet_run;
  logic       ac_run;
  logic       return_run;
  logic       alarm;
  logic [1:0] verdict;

  modport source (output valid, inlet_run, ac_run, return_run, alarm, verdict,
                  input ready);
  modport sink (input valid, inlet_run, ac_run, return_run, alarm, verdict,
                output ready);
endinterface
`default_nettype wire

### hdl/pressure_decay_test_sequencer_core.sv
`default_nettype none
// Channel   Dir  Payload                                                  Moves
// in_ch     in   cmd, pressure, inlet_delta, ac_delta, return_delta,     one request
//                elapsed_ms
// out_ch    out  inlet_run, ac_run, return_run, alarm, verdict           one result
// cfg_*     in   cfg_we, cfg_index, cfg_wdata                            one write
//
// Each request gives exactly one result. With out_ch ready, the result is shown once
// the request has passed the input register, then the result register.
// One request per clock sustained while out_ch is ready: one pass of compare/add logic
// between the two registers updates the test state.
// out_ch.ready feeds in_ch.ready combinationally: with both registers full, each
// stall cycle on out_ch holds off in_ch for that cycle.
// rst_n is synchronous: registers return to defaults, all pumps off, no verdict.
module pressure_decay_test_sequencer_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  pdts_in_if.sink                                in_ch,
  pdts_out_if.source                             out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [pdts_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [pdts_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import pdts_pkg::*;

  localparam logic signed [24:0] VOL_MAX = 25'sd8388607;
  localparam logic signed [24:0] VOL_MIN = -25'sd8388608;

  cfg_t cfg;

  pdts_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Saturate a widened sum back to 24 bits
  function automatic logic signed [23:0] sat24(input logic signed [24:0] s);
    if (s > VOL_MAX) begin
      return VOL_MAX[23:0];
    end else if (s < VOL_MIN) begin
      return VOL_MIN[23:0];
    end
    return s[23:0];
  endfunction

  function automatic logic [16:0] mag17(input logic signed [15:0] d);
    logic signed [16:0] e;
    e = 17'(d);
    return e[16] ? unsigned'(-e) : unsigned'(e);
  endfunction

  // Input register
  logic  in_valid_r;
  item_t item_r;
  logic  out_valid_r;
  logic  advance;

  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      item_r.cmd          <= in_ch.cmd;
      item_r.pressure     <= in_ch.pressure;
      item_r.inlet_delta  <= in_ch.inlet_delta;
      item_r.ac_delta     <= in_ch.ac_delta;
      item_r.return_delta <= in_ch.return_delta;
      item_r.elapsed_ms   <= in_ch.elapsed_ms;
    end
  end

  // Test state
  logic signed [23:0] inlet_vol_r, inlet_vol_nxt;
  logic signed [23:0] ac_vol_r, ac_vol_nxt;
  logic signed [23:0] rtn_vol_r, rtn_vol_nxt;
  logic signed [14:0] start_pres_r, start_pres_nxt;
  logic [2:0]         pump_run_r, pump_run_nxt;
  logic               holding_r, holding_nxt;
  logic [1:0]         pass_cnt_r, pass_cnt_nxt;
  logic [1:0]         verdict_r, verdict_nxt;
  logic               hold_armed_r, hold_armed_nxt;
  logic [15:0]        hold_left_r, hold_left_nxt;
  logic               pump_armed_r, pump_armed_nxt;
  logic [15:0]        pump_left_r, pump_left_nxt;
  logic               alarm_r, alarm_nxt;

  // Datapath terms
  logic signed [23:0] inlet_sum, ac_sum, rtn_sum;
  logic signed [24:0] fwd_target, rtn_target;
  logic               all_still;
  logic               start_too_high;
  logic signed [15:0] pres_rise;
  logic               rise_ok;
  logic [15:0]        ms_ext;
  logic               hold_expired, pump_expired;
  logic [1:0]         pass_inc;

  assign inlet_sum  = sat24(25'(inlet_vol_r) + 25'(item_r.inlet_delta));
  assign ac_sum     = sat24(25'(ac_vol_r) + 25'(item_r.ac_delta));
  assign rtn_sum    = sat24(25'(rtn_vol_r) + 25'(item_r.return_delta));
  assign fwd_target = signed'(25'(cfg.forward_stop_volume));
  assign rtn_target = -signed'(25'(cfg.return_stop_volume));
  assign all_still  = (mag17(item_r.inlet_delta) <= 17'(cfg.still_limit)) &&
                      (mag17(item_r.ac_delta) <= 17'(cfg.still_limit)) &&
                      (mag17(item_r.return_delta) <= 17'(cfg.still_limit));
  assign start_too_high = item_r.pressure > cfg.start_pressure_max;
  assign pres_rise    = 16'(item_r.pressure) - 16'(start_pres_r);
  assign rise_ok      = pres_rise < 16'(cfg.decay_limit);
  assign ms_ext       = 16'(item_r.elapsed_ms);
  assign hold_expired = ms_ext >= hold_left_r;
  assign pump_expired = ms_ext >= pump_left_r;
  assign pass_inc     = (pass_cnt_r == 2'd3) ? pass_cnt_r : pass_cnt_r + 2'd1;

  logic do_setup, do_fail, do_halt;

  // Sequencer update for one request
  always_comb begin
    inlet_vol_nxt  = inlet_vol_r;
    ac_vol_nxt     = ac_vol_r;
    rtn_vol_nxt    = rtn_vol_r;
    start_pres_nxt = start_pres_r;
    pump_run_nxt   = pump_run_r;
    holding_nxt    = holding_r;
    pass_cnt_nxt   = pass_cnt_r;
    verdict_nxt    = verdict_r;
    hold_armed_nxt = hold_armed_r;
    hold_left_nxt  = hold_left_r;
    pump_armed_nxt = pump_armed_r;
    pump_left_nxt  = pump_left_r;
    alarm_nxt      = alarm_r;
    do_setup = 1'b0;
    do_fail  = 1'b0;
    do_halt  = 1'b0;

    unique case (item_r.cmd)
      CMD_START: begin
        verdict_nxt  = VERDICT_RUNNING;
        pass_cnt_nxt = 2'd0;
        alarm_nxt    = 1'b0;
        holding_nxt  = 1'b0;
        do_setup     = 1'b1;
      end
      CMD_TICK: begin
        if (verdict_r == VERDICT_RUNNING && (hold_armed_r || pump_armed_r)) begin
          if (holding_r) begin
            // hold phase: wait out the timer, then judge the rise
            if (hold_armed_r) begin
              if (hold_expired) begin
                holding_nxt    = 1'b0;
                hold_armed_nxt = 1'b0;
                hold_left_nxt  = 16'd0;
                if (rise_ok) begin
                  pass_cnt_nxt = pass_inc;
                  if (pass_inc > 2'd1) begin
                    verdict_nxt = VERDICT_PASSED;
                    do_halt     = 1'b1;
                  end else begin
                    do_setup = 1'b1;
                  end
                end else begin
                  do_fail = 1'b1;
                end
              end else begin
                hold_left_nxt = hold_left_r - ms_ext;
              end
            end
          end else begin
            // pump phase: accumulate and stop pumps at target
            inlet_vol_nxt = inlet_sum;
            ac_vol_nxt    = ac_sum;
            rtn_vol_nxt   = rtn_sum;
            if (pump_run_r[PUMP_INLET] && 25'(inlet_sum) >= fwd_target) begin
              pump_run_nxt[PUMP_INLET] = 1'b0;
            end
            if (pump_run_r[PUMP_AC] && 25'(ac_sum) >= fwd_target) begin
              pump_run_nxt[PUMP_AC] = 1'b0;
            end
            if (pump_run_r[PUMP_RETURN] && 25'(rtn_sum) <= rtn_target) begin
              pump_run_nxt[PUMP_RETURN] = 1'b0;
            end
            if (pump_run_r == 3'b000 && all_still) begin
              holding_nxt    = 1'b1;
              hold_armed_nxt = 1'b1;
              hold_left_nxt  = cfg.hold_time_ms;
              pump_armed_nxt = 1'b0;
              pump_left_nxt  = 16'd0;
            end else if (pump_armed_r) begin
              if (pump_expired) begin
                do_fail = 1'b1;
              end else begin
                pump_left_nxt = pump_left_r - ms_ext;
              end
            end
          end
        end
      end
      CMD_STOP: do_halt = 1'b1;
      default: ;
    endcase

    // Setup: fail at once if the start pressure is too high
    if (do_setup) begin
      if (start_too_high) begin
        do_fail = 1'b1;
      end else begin
        start_pres_nxt = item_r.pressure;
        inlet_vol_nxt  = '0;
        ac_vol_nxt     = '0;
        rtn_vol_nxt    = '0;
        pump_run_nxt   = 3'b111;
        pump_armed_nxt = 1'b1;
        pump_left_nxt  = cfg.pump_timeout_ms;
        hold_armed_nxt = 1'b0;
        hold_left_nxt  = 16'd0;
        holding_nxt    = 1'b0;
      end
    end

    if (do_fail) begin
      verdict_nxt = VERDICT_FAILED;
      alarm_nxt   = 1'b1;
      do_halt     = 1'b1;
    end

    if (do_halt) begin
      pump_run_nxt   = 3'b000;
      hold_armed_nxt = 1'b0;
      hold_left_nxt  = 16'd0;
      pump_armed_nxt = 1'b0;
      pump_left_nxt  = 16'd0;
      holding_nxt    = 1'b0;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inlet_vol_r  <= '0;
      ac_vol_r     <= '0;
      rtn_vol_r    <= '0;
      start_pres_r <= '0;
      pump_run_r   <= 3'b000;
      holding_r    <= 1'b0;
      pass_cnt_r   <= 2'd0;
      verdict_r    <= VERDICT_RUNNING;
      hold_armed_r <= 1'b0;
      hold_left_r  <= 16'd0;
      pump_armed_r <= 1'b0;
      pump_left_r  <= 16'd0;
      alarm_r      <= 1'b0;
    end else if (advance) begin
      inlet_vol_r  <= inlet_vol_nxt;
      ac_vol_r     <= ac_vol_nxt;
      rtn_vol_r    <= rtn_vol_nxt;
      start_pres_r <= start_pres_nxt;
      pump_run_r   <= pump_run_nxt;
      holding_r    <= holding_nxt;
      pass_cnt_r   <= pass_cnt_nxt;
      verdict_r    <= verdict_nxt;
      hold_armed_r <= hold_armed_nxt;
      hold_left_r  <= hold_left_nxt;
      pump_armed_r <= pump_armed_nxt;
      pump_left_r  <= pump_left_nxt;
      alarm_r      <= alarm_nxt;
    end
  end

  // Result register
  logic [2:0] out_run_r;
  logic       out_alarm_r;
  logic [1:0] out_verdict_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_run_r     <= pump_run_nxt;
      out_alarm_r   <= alarm_nxt;
      out_verdict_r <= verdict_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.inlet_run  = out_run_r[PUMP_INLET];
  assign out_ch.ac_run     = out_run_r[PUMP_AC];
  assign out_ch.return_run = out_run_r[PUMP_RETURN];
  assign out_ch.alarm      = out_alarm_r;
  assign out_ch.verdict    = out_verdict_r;

  // Hold flag and hold timer move together
  a_hold_armed: assert property (@(posedge clk) disable iff (!rst_n)
    holding_r == hold_armed_r)
    else $error("holding flag and hold timer disagree");

  // The two timers are never armed at once
  a_one_timer: assert property (@(posedge clk) disable iff (!rst_n)
    !(hold_armed_r && pump_armed_r))
    else $error("hold and pump timers both armed");

  // A latched verdict leaves everything halted
  a_verdict_halt: assert property (@(posedge clk) disable iff (!rst_n)
    verdict_r != VERDICT_RUNNING |-> (pump_run_r == 3'b000 && !hold_armed_r && !pump_armed_r))
    else $error("verdict latched with pumps or timers active");

  // Alarm only with a failed verdict
  a_alarm_fail: assert property (@(posedge clk) disable iff (!rst_n)
    alarm_r |-> verdict_r == VERDICT_FAILED)
    else $error("alarm without failed verdict");

  // Pumps only run while the pump timeout is armed
  a_run_armed: assert property (@(posedge clk) disable iff (!rst_n)
    pump_run_r != 3'b000 |-> pump_armed_r)
    else $error("pump running without timeout armed");

endmodule
`default_nettype wire

### hdl/pdts_cfg_regs.sv
`default_nettype none
module pdts_cfg_regs (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [pdts_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [pdts_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output pdts_pkg::cfg_t                         cfg
);
  import pdts_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Register decode; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_DECAY_LIMIT:    cfg_nxt.decay_limit         = signed'(cfg_wdata[13:0]);
        REG_START_PRES_MAX: cfg_nxt.start_pressure_max  = signed'(cfg_wdata[14:0]);
        REG_HOLD_TIME:      cfg_nxt.hold_time_ms        = cfg_wdata;
        REG_PUMP_TIMEOUT:   cfg_nxt.pump_timeout_ms     = cfg_wdata;
        REG_FWD_STOP_VOL:   cfg_nxt.forward_stop_volume = cfg_wdata;
        REG_RTN_STOP_VOL:   cfg_nxt.return_stop_volume  = cfg_wdata;
        REG_STILL_LIMIT:    cfg_nxt.still_limit         = cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.decay_limit         <= 14'sd50;
      cfg_r.start_pressure_max  <= -15'sd3250;
      cfg_r.hold_time_ms        <= 16'd5000;
      cfg_r.pump_timeout_ms     <= 16'd5000;
      cfg_r.forward_stop_volume <= 16'd280;
      cfg_r.return_stop_volume  <= 16'd900;
      cfg_r.still_limit         <= 8'd2;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

### tb/pressure_decay_test_sequencer_core_tb.sv
`default_nettype none
module pressure_decay_test_sequencer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pdts_pkg::*;

  // cmd value with no meaning to the block
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int VOL_MAX = 8388607;
  localparam int VOL_MIN = -8388608;
  localparam int TOTAL_REQUESTS = 1900;

  typedef struct packed {
    logic       inlet_run;
    logic       ac_run;
    logic       return_run;
    logic       alarm;
    logic [1:0] verdict;
  } status_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  pdts_in_if  in_ch ();
  pdts_out_if out_ch ();

  pressure_decay_test_sequencer_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow of the register file and of the sequencer state
  cfg_t        regs;
  int          vol_inlet, vol_ac, vol_return, base_pressure;
  logic [2:0]  pumps_on;
  bit          in_hold, alarm_q, hold_live, pump_live;
  int          passes;
  logic [1:0]  verdict_q;
  int unsigned hold_ms_left, pump_ms_left;

  status_t pending_status[$];
  int      mismatches = 0;
  int      sent_count = 0;
  int      burst_left = 0;
  bit      gaps_on = 1'b1;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sequencer predictor
  // ---------------------------------------------------------------------------
  function automatic cfg_t default_config();
    cfg_t c;
    c.decay_limit         = 14'sd50;
    c.start_pressure_max  = -15'sd3250;
    c.hold_time_ms        = 16'd5000;
    c.pump_timeout_ms     = 16'd5000;
    c.forward_stop_volume = 16'd280;
    c.return_stop_volume  = 16'd900;
    c.still_limit         = 8'd2;
    return c;
  endfunction

  function automatic void reset_sequencer();
    vol_inlet = 0; vol_ac = 0; vol_return = 0; base_pressure = 0;
    pumps_on = '0; in_hold = 0; alarm_q = 0; passes = 0;
    verdict_q = VERDICT_RUNNING;
    hold_live = 0; pump_live = 0; hold_ms_left = 0; pump_ms_left = 0;
  endfunction

  function automatic int sat_add(int a, int d);
    int s;
    s = a + d;
    if (s > VOL_MAX) return VOL_MAX;
    if (s < VOL_MIN) return VOL_MIN;
    return s;
  endfunction

  function automatic int magnitude(int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic void halt_pumps();
    pumps_on = '0;
    hold_live = 0; hold_ms_left = 0;
    pump_live = 0; pump_ms_left = 0;
    in_hold = 0;
  endfunction

  function automatic void declare_fail();
    verdict_q = VERDICT_FAILED;
    alarm_q = 1;
    halt_pumps();
  endfunction

  // Setup: reject a high start pressure, else latch it and run the pumps
  function automatic void begin_cycle(int p);
    if (p > int'(regs.start_pressure_max)) begin
      declare_fail();
      return;
    end
    base_pressure = p;
    vol_inlet = 0; vol_ac = 0; vol_return = 0;
    pumps_on = 3'b111;
    pump_live = 1; pump_ms_left = regs.pump_timeout_ms;
    hold_live = 0; hold_ms_left = 0;
    in_hold = 0;
  endfunction

  function automatic void control_tick(int p, int di, int da, int dr, int unsigned ms);
    logic [2:0] prev;
    int lim;
    if (verdict_q != VERDICT_RUNNING || (!hold_live && !pump_live)) return;
    // hold phase: deltas ignored, judge the rise at expiry
    if (in_hold) begin
      if (hold_live) begin
        if (ms >= hold_ms_left) begin
          hold_live = 0; hold_ms_left = 0; in_hold = 0;
          if (p - base_pressure < int'(regs.decay_limit)) begin
            if (passes < 3) passes++;
            if (passes > 1) begin
              verdict_q = VERDICT_PASSED;
              halt_pumps();
            end else begin
              begin_cycle(p);
            end
          end else begin
            declare_fail();
          end
        end else begin
          hold_ms_left -= ms;
        end
      end
      return;
    end
    // pump phase
    prev = pumps_on;
    lim = int'(regs.still_limit);
    vol_inlet  = sat_add(vol_inlet, di);
    vol_ac     = sat_add(vol_ac, da);
    vol_return = sat_add(vol_return, dr);
    if (prev[PUMP_INLET] && vol_inlet >= int'(regs.forward_stop_volume))
      pumps_on[PUMP_INLET] = 1'b0;
    if (prev[PUMP_AC] && vol_ac >= int'(regs.forward_stop_volume))
      pumps_on[PUMP_AC] = 1'b0;
    if (prev[PUMP_RETURN] && vol_return <= -int'(regs.return_stop_volume))
      pumps_on[PUMP_RETURN] = 1'b0;
    // stillness is checked before the timeout
    if (prev == 3'b000 && magnitude(di) <= lim && magnitude(da) <= lim &&
        magnitude(dr) <= lim) begin
      in_hold = 1;
      hold_live = 1; hold_ms_left = regs.hold_time_ms;
      pump_live = 0; pump_ms_left = 0;
      return;
    end
    if (pump_live) begin
      if (ms >= pump_ms_left) begin
        pump_live = 0; pump_ms_left = 0;
        declare_fail();
      end else begin
        pump_ms_left -= ms;
      end
    end
  endfunction

  function automatic void advance_sequencer(item_t it);
    status_t s;
    case (it.cmd)
      CMD_START: begin
        verdict_q = VERDICT_RUNNING; passes = 0; alarm_q = 0; in_hold = 0;
        begin_cycle(int'(it.pressure));
      end
      CMD_TICK: control_tick(int'(it.pressure), int'(it.inlet_delta), int'(it.ac_delta),
                             int'(it.return_delta), int'(it.elapsed_ms));
      CMD_STOP: halt_pumps();
      default: ;
    endcase
    s.inlet_run  = pumps_on[PUMP_INLET];
    s.ac_run     = pumps_on[PUMP_AC];
    s.return_run = pumps_on[PUMP_RETURN];
    s.alarm      = alarm_q;
    s.verdict    = verdict_q;
    pending_status.push_back(s);
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      if (mismatches < 40)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    status_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_status.size() == 0) begin
        if (mismatches < 40)
          $display("%0t: unexpected result, expected none, actual verdict %0d",
                   $time, out_ch.verdict);
        mismatches++;
      end else begin
        want = pending_status.pop_front();
        check_field("inlet_run", want.inlet_run, out_ch.inlet_run);
        check_field("ac_run", want.ac_run, out_ch.ac_run);
        check_field("return_run", want.return_run, out_ch.return_run);
        check_field("alarm", want.alarm, out_ch.alarm);
        check_field("verdict", want.verdict, out_ch.verdict);
      end
    end
  end

  // Result backpressure: switches between stall patterns
  initial begin
    int mode, span, phase;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    phase = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(50, 300);
      repeat (span) begin
        @(negedge clk);
        phase++;
        case (mode)
          0: out_ch.ready = 1'b1;
          1: out_ch.ready = ($urandom_range(0, 3) != 0);
          2: out_ch.ready = (phase % 5 != 0);
          default: out_ch.ready = ($urandom_range(0, 9) == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request driver and register writes
  // ---------------------------------------------------------------------------
  function automatic item_t make_req(logic [1:0] c, int p, int di, int da, int dr, int ms);
    item_t it;
    it.cmd          = c;
    it.pressure     = 15'(p);
    it.inlet_delta  = 16'(di);
    it.ac_delta     = 16'(da);
    it.return_delta = 16'(dr);
    it.elapsed_ms   = 10'(ms);
    return it;
  endfunction

  task automatic send_request(item_t it);
    @(negedge clk);
    in_ch.cmd          = it.cmd;
    in_ch.pressure     = it.pressure;
    in_ch.inlet_delta  = it.inlet_delta;
    in_ch.ac_delta     = it.ac_delta;
    in_ch.return_delta = it.return_delta;
    in_ch.elapsed_ms   = it.elapsed_ms;
    in_ch.valid        = 1'b1;
    forever begin
      @(posedge clk);
      if (in_ch.ready) break;
    end
    advance_sequencer(it);
    sent_count++;
  endtask

  // Bursts of random length, separated by random gaps while gaps_on is set
  task automatic issue(item_t it);
    if (burst_left == 0) begin
      if (gaps_on) begin
        @(negedge clk);
        in_ch.valid = 1'b0;
        repeat ($urandom_range(0, 6)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    send_request(it);
  endtask

  // Sender pauses until every outstanding request has its result
  task automatic wait_all_results();
    @(negedge clk);
    in_ch.valid = 1'b0;
    burst_left = 0;
    while (pending_status.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1; cfg_index = idx; cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_DECAY_LIMIT:    regs.decay_limit         = val[13:0];
      REG_START_PRES_MAX: regs.start_pressure_max  = val[14:0];
      REG_HOLD_TIME:      regs.hold_time_ms        = val;
      REG_PUMP_TIMEOUT:   regs.pump_timeout_ms     = val;
      REG_FWD_STOP_VOL:   regs.forward_stop_volume = val;
      REG_RTN_STOP_VOL:   regs.return_stop_volume  = val;
      REG_STILL_LIMIT:    regs.still_limit         = val[7:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(cfg_t c);
    wait_all_results();
    write_reg(REG_DECAY_LIMIT, {{2{c.decay_limit[13]}}, c.decay_limit});
    write_reg(REG_START_PRES_MAX, {c.start_pressure_max[14], c.start_pressure_max});
    write_reg(REG_HOLD_TIME, c.hold_time_ms);
    write_reg(REG_PUMP_TIMEOUT, c.pump_timeout_ms);
    write_reg(REG_FWD_STOP_VOL, c.forward_stop_volume);
    write_reg(REG_RTN_STOP_VOL, c.return_stop_volume);
    write_reg(REG_STILL_LIMIT, {8'h00, c.still_limit});
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------
  function automatic int any_pressure();
    return int'($urandom_range(0, 20000)) - 10000;
  endfunction

  function automatic int any_delta();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic int clip_pressure(int p);
    if (p > 10000) return 10000;
    if (p < -10000) return -10000;
    return p;
  endfunction

  function automatic cfg_t random_config();
    cfg_t c;
    c.decay_limit        = 14'(int'($urandom_range(0, 10000)) - 5000);
    c.start_pressure_max = 15'(-int'($urandom_range(0, 10000)));
    c.hold_time_ms       = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(0, 20000))
                                                        : 16'($urandom_range(0, 3000));
    c.pump_timeout_ms    = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535))
                                                       : 16'($urandom_range(0, 5000));
    c.forward_stop_volume = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535))
                                                        : 16'($urandom_range(0, 2000));
    c.return_stop_volume  = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535))
                                                        : 16'($urandom_range(0, 2000));
    c.still_limit = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                : 8'($urandom_range(0, 20));
    return c;
  endfunction

  function automatic int start_pressure_pick();
    int top;
    top = int'(regs.start_pressure_max);
    if ($urandom_range(0, 99) < 85) return -10000 + int'($urandom_range(0, top + 10000));
    return any_pressure();
  endfunction

  // Mostly well-formed test sequences steered by the predicted state
  function automatic item_t next_request();
    int r, p, ms, lim, fwd, rtn, span;
    int d[3];
    bit live;
    r = $urandom_range(0, 99);
    live = (verdict_q == VERDICT_RUNNING) && (hold_live || pump_live);
    if ((!live && r < 60) || r < 3)
      return make_req(CMD_START, start_pressure_pick(), any_delta(), any_delta(),
                      any_delta(), $urandom_range(0, 1023));
    if (r < 5)
      return make_req(CMD_STOP, any_pressure(), any_delta(), any_delta(), any_delta(),
                      $urandom_range(0, 1023));
    if (r < 6)
      return make_req(CMD_UNUSED, any_pressure(), any_delta(), any_delta(), any_delta(),
                      $urandom_range(0, 1023));
    if (r < 12 || !live)
      return make_req(CMD_TICK, any_pressure(), any_delta(), any_delta(), any_delta(),
                      $urandom_range(0, 1023));
    if (in_hold) begin
      span = int'(regs.hold_time_ms) / int'($urandom_range(1, 4));
      ms = (span > 1023) ? 1023 : span;
      if ($urandom_range(0, 9) == 0) ms = $urandom_range(0, 1023);
      // pressure near the decay limit, mostly on the passing side
      p = clip_pressure(base_pressure + int'(regs.decay_limit) +
                        int'($urandom_range(0, 40)) - 28);
      if ($urandom_range(0, 9) == 0) p = any_pressure();
      return make_req(CMD_TICK, p, any_delta(), any_delta(), any_delta(), ms);
    end
    lim = int'(regs.still_limit);
    fwd = int'(regs.forward_stop_volume);
    rtn = int'(regs.return_stop_volume);
    for (int i = 0; i < 3; i++) begin
      if (pumps_on[i]) begin
        if (i == PUMP_RETURN) begin
          d[i] = -int'($urandom_range(rtn / 4, rtn / 2 + 1));
          if (d[i] < -32768) d[i] = -32768;
        end else begin
          d[i] = $urandom_range(fwd / 4, fwd / 2 + 1);
          if (d[i] > 32767) d[i] = 32767;
        end
      end else if ($urandom_range(0, 99) < 85) begin
        d[i] = int'($urandom_range(0, 2 * lim)) - lim;
      end else begin
        d[i] = any_delta();
      end
    end
    span = int'(regs.pump_timeout_ms) / int'($urandom_range(6, 16));
    ms = (span > 1023) ? 1023 : span;
    if ($urandom_range(0, 9) == 0) ms = $urandom_range(0, 1023);
    return make_req(CMD_TICK, any_pressure(), d[PUMP_INLET], d[PUMP_AC], d[PUMP_RETURN], ms);
  endfunction

  task automatic run_phase(cfg_t c, int n);
    apply_config(c);
    gaps_on = ($urandom_range(0, 2) != 0);
    repeat (n) issue(next_request());
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset configuration: idle ticks, early fail, restart, two passes
  task automatic test_directed_sequence();
    issue(make_req(CMD_TICK, 10000, 32767, -32768, 32767, 1023));
    issue(make_req(CMD_UNUSED, -10000, -1, -1, -1, 1023));
    issue(make_req(CMD_STOP, 0, 0, 0, 0, 0));
    issue(make_req(CMD_START, 10000, 0, 0, 0, 0));
    issue(make_req(CMD_TICK, -10000, 100, 100, -100, 5));
    issue(make_req(CMD_START, -3250, 0, 0, 0, 0));
    issue(make_req(CMD_START, -10000, 0, 0, 0, 0));
    // all targets crossed on one tick, not yet still
    issue(make_req(CMD_TICK, -10000, 32767, 32767, -32768, 0));
    issue(make_req(CMD_TICK, -10000, 2, -2, 2, 1023));
    repeat (4) issue(make_req(CMD_TICK, 5000, -32768, 32767, -32768, 1023));
    // rise of 49 passes, setup reruns
    issue(make_req(CMD_TICK, -9951, 0, 0, 0, 1023));
    issue(make_req(CMD_TICK, -9000, 280, 280, -900, 1));
    issue(make_req(CMD_TICK, -9000, 0, 0, 0, 0));
    repeat (4) issue(make_req(CMD_TICK, -9951, 0, 0, 0, 1023));
    issue(make_req(CMD_TICK, -9902, 0, 0, 0, 1023));
    issue(make_req(CMD_TICK, -9902, 7, 7, 7, 1023));
  endtask

  // Zero intervals, timeout, stillness ahead of timeout, failing rise
  task automatic test_zero_intervals();
    cfg_t c;
    c = default_config();
    c.hold_time_ms = 16'd0;
    c.pump_timeout_ms = 16'd0;
    apply_config(c);
    issue(make_req(CMD_START, -10000, 0, 0, 0, 0));
    issue(make_req(CMD_TICK, -10000, 0, 0, 0, 0));
    c.pump_timeout_ms = 16'd1000;
    apply_config(c);
    issue(make_req(CMD_START, -10000, 0, 0, 0, 0));
    issue(make_req(CMD_TICK, -10000, 300, 280, -901, 999));
    issue(make_req(CMD_TICK, -10000, 0, 0, 0, 1023));
    issue(make_req(CMD_TICK, -9950, 0, 0, 0, 0));
  endtask

  // Volume totals clamp at the 24-bit limits: observed through stop timing
  task automatic test_volume_saturation();
    cfg_t c;
    c = default_config();
    c.pump_timeout_ms = 16'hFFFF;
    apply_config(c);
    issue(make_req(CMD_START, -10000, 0, 0, 0, 0));
    repeat (260) issue(make_req(CMD_TICK, any_pressure(), -32768, 32767, 32767, 0));
    repeat (262) issue(make_req(CMD_TICK, any_pressure(), 32767, 32767, -32768, 0));
    issue(make_req(CMD_STOP, 0, 0, 0, 0, 0));
  endtask

  // Register extremes at both ends
  task automatic test_config_extremes();
    cfg_t c;
    c.decay_limit = -14'sd5000;
    c.start_pressure_max = -15'sd10000;
    c.hold_time_ms = 16'd0;
    c.pump_timeout_ms = 16'd0;
    c.forward_stop_volume = 16'd0;
    c.return_stop_volume = 16'd0;
    c.still_limit = 8'd0;
    run_phase(c, 60);
    c.decay_limit = 14'sd5000;
    c.start_pressure_max = 15'sd0;
    c.hold_time_ms = 16'hFFFF;
    c.pump_timeout_ms = 16'hFFFF;
    c.forward_stop_volume = 16'hFFFF;
    c.return_stop_volume = 16'hFFFF;
    c.still_limit = 8'hFF;
    run_phase(c, 80);
  endtask

  // Random registers and sequences until the request budget is spent
  task automatic test_random_phases();
    run_phase(default_config(), 150);
    while (sent_count < TOTAL_REQUESTS)
      run_phase(random_config(), $urandom_range(80, 200));
  endtask

  // ---------------------------------------------------------------------------
  // Main flow
  // ---------------------------------------------------------------------------
  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_TICK;
    in_ch.pressure = '0;
    in_ch.inlet_delta = '0;
    in_ch.ac_delta = '0;
    in_ch.return_delta = '0;
    in_ch.elapsed_ms = '0;
    cfg_we = 1'b0;
    cfg_index = REG_DECAY_LIMIT;
    cfg_wdata = '0;
    regs = default_config();
    reset_sequencer();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_sequence();
    test_zero_intervals();
    test_volume_saturation();
    test_config_extremes();
    test_random_phases();

    wait_all_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

### sim.f
hdl/pdts_pkg.sv
hdl/pdts_if.sv
hdl/pdts_cfg_regs.sv
hdl/pressure_decay_test_sequencer_core.sv
tb/pressure_decay_test_sequencer_core_tb.sv
